/* sv/bqf_pkg.sv */
// Shared types and constants for the multichannel biquad filter.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package bqf_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int COEF_W    = 24;
  localparam int COEF_FRAC = 20;
  localparam int CHAN_W    = 3;
  localparam int REG_IDX_W = 3;

  // Coefficient register indexes on the configuration port
  typedef enum logic [REG_IDX_W-1:0] {
    REG_FEED_0 = 3'd0,
    REG_FEED_1 = 3'd1,
    REG_FEED_2 = 3'd2,
    REG_BACK_1 = 3'd3,
    REG_BACK_2 = 3'd4
  } bqf_reg_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [CHAN_W-1:0]          channel;
  } bqf_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered;
    logic [CHAN_W-1:0]          out_channel;
  } bqf_out_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] f0;
    logic signed [COEF_W-1:0] f1;
    logic signed [COEF_W-1:0] f2;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
  } bqf_coef_t;

  // One history entry: two past inputs, two past outputs
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x1;
    logic signed [SAMPLE_W-1:0] x2;
    logic signed [SAMPLE_W-1:0] y1;
    logic signed [SAMPLE_W-1:0] y2;
  } bqf_hist_t;

  // Side information that travels with an item down the pipeline
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] x1;
    logic signed [SAMPLE_W-1:0] y1;
    logic [CHAN_W-1:0]          channel;
    logic                       ok;
  } bqf_tag_t;

  typedef struct packed {
    bqf_tag_t                   tag;
    logic signed [SAMPLE_W-1:0] y;
  } bqf_done_t;

endpackage

`default_nettype wire

/* sv/bqf_hist_mem.sv */
// Per-channel history memory of the biquad filter, with a registered read.
// Depends on bqf_pkg for the history entry type.
`timescale 1ns / 1ps
`default_nettype none

module bqf_hist_mem #(
  parameter int CHANNELS = 8,
  parameter int IDX_W    = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  logic [IDX_W-1:0]    rd_addr,
  input  logic                rd_ok,
  output bqf_pkg::bqf_hist_t  hist,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_addr,
  input  bqf_pkg::bqf_hist_t  wr_data
);
  import bqf_pkg::*;

  bqf_hist_t           mem [CHANNELS];
  logic [CHANNELS-1:0] filled;
  bqf_hist_t           rdata;
  logic                rgood;

  // Entries never written read as zero history
  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
      rgood  <= 1'b0;
    end else begin
      if (wr_en) begin
        filled[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rgood <= rd_ok && filled[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  assign hist = rgood ? rdata : '0;

endmodule

`default_nettype wire

/* sv/bqf_mac.sv */
// Multiply-accumulate pipeline of the biquad filter: five products, adder
// tree, rounding and saturation. Depends on bqf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bqf_mac (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       issue,
  input  bqf_pkg::bqf_tag_t          issue_tag,
  output logic                       issue_ready,
  input  bqf_pkg::bqf_hist_t         hist,
  input  bqf_pkg::bqf_coef_t         coef,
  input  logic [bqf_pkg::CHAN_W-1:0] probe_ch,
  output logic                       probe_hit,
  output logic                       done_valid,
  input  logic                       done_ready,
  output bqf_pkg::bqf_done_t         done
);
  import bqf_pkg::*;

  localparam int STAGES = 5;
  localparam int PROD_W = SAMPLE_W + COEF_W;
  localparam int ACC_W  = PROD_W + 3;
  localparam int YF_W   = ACC_W - COEF_FRAC;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC - 1);
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  logic [STAGES:1]           v;
  logic [STAGES:1]           adv;
  bqf_tag_t                  tg [STAGES:1];
  logic signed [PROD_W-1:0]  p0, p1, p2, p3, p4;
  logic signed [ACC_W-1:0]   sa, sb, sc, sd, se, acc;
  logic [YF_W-1:0]           yf;
  logic [YF_W-SAMPLE_W:0]    yhi;
  logic signed [SAMPLE_W-1:0] y;

  // Stage k moves on when empty or when the stage after it moves on
  always_comb begin
    adv[STAGES] = !v[STAGES] || done_ready;
    for (int k = STAGES - 1; k >= 1; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end

  assign issue_ready = adv[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[1]) begin
        v[1] <= issue;
      end
      for (int k = 2; k <= STAGES; k++) begin
        if (adv[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      tg[1] <= issue_tag;
    end
    if (adv[2]) begin
      tg[2] <= '{x: tg[1].x, x1: hist.x1, y1: hist.y1,
                 channel: tg[1].channel, ok: tg[1].ok};
      p0 <= tg[1].x * coef.f0;
      p1 <= hist.x1 * coef.f1;
      p2 <= hist.x2 * coef.f2;
      p3 <= hist.y1 * coef.b1;
      p4 <= hist.y2 * coef.b2;
    end
    if (adv[3]) begin
      tg[3] <= tg[2];
      sa <= ACC_W'(p0) + ACC_W'(p1);
      sb <= ACC_W'(p2) + ACC_W'(p3);
      sc <= ACC_W'(p4) + ROUND_HALF;
    end
    if (adv[4]) begin
      tg[4] <= tg[3];
      sd <= sa + sb;
      se <= sc;
    end
    if (adv[5]) begin
      tg[5] <= tg[4];
      acc <= sd + se;
    end
  end

  // Floor shift, then clamp when the upper bits are not all sign
  always_comb begin
    yf  = acc[ACC_W-1:COEF_FRAC];
    yhi = yf[YF_W-1:SAMPLE_W-1];
    if ((&yhi) || !(|yhi)) begin
      y = yf[SAMPLE_W-1:0];
    end else if (yf[YF_W-1]) begin
      y = SAMPLE_MIN;
    end else begin
      y = SAMPLE_MAX;
    end
  end

  // Any in-flight item on the probed channel still owes a history write
  always_comb begin
    probe_hit = 1'b0;
    for (int k = 1; k <= STAGES; k++) begin
      if (v[k] && tg[k].ok && (tg[k].channel == probe_ch)) begin
        probe_hit = 1'b1;
      end
    end
  end

  assign done_valid = v[STAGES];
  assign done.tag   = tg[STAGES];
  assign done.y     = y;

endmodule

`default_nettype wire

/* sv/multichannel_biquad_filter.sv */
// Top level of the multichannel Direct Form I biquad filter.
// Depends on bqf_pkg, bqf_hist_mem and bqf_mac.
`timescale 1ns / 1ps
`default_nettype none

//  Channel  Beat carries               Handshake
//  samp     sample, channel            samp_valid / samp_ready
//  res      filtered, out_channel      res_valid  / res_ready
//  cfg      cfg_index, cfg_data        cfg_valid  / cfg_ready (always ready)
//
//  A sample beat passes the five pipeline stages, then the result register.
//  Beats on different channels enter one per cycle unless the pipeline
//  stalls; a beat on a channel that is still in the pipeline waits for the
//  history write-back, so one channel alone takes no new beat until its last
//  one leaves the pipeline, closing the history read-modify-write loop.
//  Reset clears valid flags at once: no clearing pass.
//  A stalled result register holds; earlier stages keep filling behind it.

module multichannel_biquad_filter #(
  parameter int CHANNELS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          samp_valid,
  output logic                          samp_ready,
  input  bqf_pkg::bqf_in_t              samp,
  output logic                          res_valid,
  input  logic                          res_ready,
  output bqf_pkg::bqf_out_t             res,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bqf_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [bqf_pkg::COEF_W-1:0]    cfg_data
);
  import bqf_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam bqf_coef_t COEF_RESET = '{
    f0: COEF_W'(1) << COEF_FRAC,
    f1: '0,
    f2: '0,
    b1: '0,
    b2: '0
  };

  bqf_coef_t  coef;
  bqf_hist_t  hist;
  bqf_hist_t  wr_data;
  bqf_tag_t   issue_tag;
  bqf_done_t  done;
  logic       ch_ok;
  logic       probe_hit;
  logic       hazard;
  logic       issue_ready;
  logic       take;
  logic       done_valid;
  logic       done_ready;
  logic       done_fire;
  logic       wr_en;

  // Coefficient registers; writes to unknown indexes drop silently
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= COEF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FEED_0: begin
          coef.f0 <= cfg_data;
        end
        REG_FEED_1: begin
          coef.f1 <= cfg_data;
        end
        REG_FEED_2: begin
          coef.f2 <= cfg_data;
        end
        REG_BACK_1: begin
          coef.b1 <= cfg_data;
        end
        REG_BACK_2: begin
          coef.b2 <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // Channels beyond the memory read zero history and write nothing back
  assign ch_ok = 32'(samp.channel) < CHANNELS;

  // Hold the beat while its channel has a write-back outstanding
  assign hazard     = ch_ok && probe_hit;
  assign samp_ready = issue_ready && !hazard;
  assign take       = samp_valid && samp_ready;

  always_comb begin
    issue_tag         = '0;
    issue_tag.x       = samp.sample;
    issue_tag.channel = samp.channel;
    issue_tag.ok      = ch_ok;
  end

  bqf_hist_mem #(
    .CHANNELS (CHANNELS),
    .IDX_W    (IDX_W)
  ) u_hist (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (take),
    .rd_addr (IDX_W'(samp.channel)),
    .rd_ok   (ch_ok),
    .hist    (hist),
    .wr_en   (wr_en),
    .wr_addr (IDX_W'(done.tag.channel)),
    .wr_data (wr_data)
  );

  bqf_mac u_mac (
    .clk         (clk),
    .rst         (rst),
    .issue       (samp_valid && !hazard),
    .issue_tag   (issue_tag),
    .issue_ready (issue_ready),
    .hist        (hist),
    .coef        (coef),
    .probe_ch    (samp.channel),
    .probe_hit   (probe_hit),
    .done_valid  (done_valid),
    .done_ready  (done_ready),
    .done        (done)
  );

  // Write back the shifted history as the result leaves the pipeline
  assign done_ready = !res_valid || res_ready;
  assign done_fire  = done_valid && done_ready;
  assign wr_en      = done_fire && done.tag.ok;

  always_comb begin
    wr_data.x1 = done.tag.x;
    wr_data.x2 = done.tag.x1;
    wr_data.y1 = done.y;
    wr_data.y2 = done.tag.y1;
  end

  // Result register: advance on a finished item, drop the beat once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (done_fire) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      res.filtered    <= done.y;
      res.out_channel <= done.tag.channel;
    end
  end

endmodule

`default_nettype wire
